// ===== design/rvdec_pkg.sv =====
`default_nettype none

package rvdec_pkg;

   // Word that stops the core
   localparam logic [31:0] HALT_WORD = 32'h0ff00513;

   // Major opcodes, bits 6:0
   localparam logic [6:0] OPC_OP     = 7'b0110011;
   localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_LUI    = 7'b0110111;

   // funct7 value that selects the alternate forms
   localparam logic [6:0] FUNCT7_ALT = 7'h20;

   // Dense operation codes
   localparam int unsigned OP_W = 6;
   localparam logic [OP_W-1:0] OP_HALT    = 6'd0;
   localparam logic [OP_W-1:0] OP_ADD     = 6'd1;
   localparam logic [OP_W-1:0] OP_SUB     = 6'd2;
   localparam logic [OP_W-1:0] OP_AND     = 6'd3;
   localparam logic [OP_W-1:0] OP_OR      = 6'd4;
   localparam logic [OP_W-1:0] OP_XOR     = 6'd5;
   localparam logic [OP_W-1:0] OP_SLL     = 6'd6;
   localparam logic [OP_W-1:0] OP_SRL     = 6'd7;
   localparam logic [OP_W-1:0] OP_SRA     = 6'd8;
   localparam logic [OP_W-1:0] OP_SLT     = 6'd9;
   localparam logic [OP_W-1:0] OP_SLTU    = 6'd10;
   localparam logic [OP_W-1:0] OP_ADDI    = 6'd11;
   localparam logic [OP_W-1:0] OP_ANDI    = 6'd12;
   localparam logic [OP_W-1:0] OP_ORI     = 6'd13;
   localparam logic [OP_W-1:0] OP_XORI    = 6'd14;
   localparam logic [OP_W-1:0] OP_SLLI    = 6'd15;
   localparam logic [OP_W-1:0] OP_SRLI    = 6'd16;
   localparam logic [OP_W-1:0] OP_SRAI    = 6'd17;
   localparam logic [OP_W-1:0] OP_LB      = 6'd18;
   localparam logic [OP_W-1:0] OP_LBU     = 6'd19;
   localparam logic [OP_W-1:0] OP_LH      = 6'd20;
   localparam logic [OP_W-1:0] OP_LHU     = 6'd21;
   localparam logic [OP_W-1:0] OP_LW      = 6'd22;
   localparam logic [OP_W-1:0] OP_SB      = 6'd23;
   localparam logic [OP_W-1:0] OP_SH      = 6'd24;
   localparam logic [OP_W-1:0] OP_SW      = 6'd25;
   localparam logic [OP_W-1:0] OP_BEQ     = 6'd26;
   localparam logic [OP_W-1:0] OP_BGE     = 6'd27;
   localparam logic [OP_W-1:0] OP_BGEU    = 6'd28;
   localparam logic [OP_W-1:0] OP_BLT     = 6'd29;
   localparam logic [OP_W-1:0] OP_BLTU    = 6'd30;
   localparam logic [OP_W-1:0] OP_BNE     = 6'd31;
   localparam logic [OP_W-1:0] OP_JAL     = 6'd32;
   localparam logic [OP_W-1:0] OP_JALR    = 6'd33;
   localparam logic [OP_W-1:0] OP_AUIPC   = 6'd34;
   localparam logic [OP_W-1:0] OP_LUI     = 6'd35;
   localparam logic [OP_W-1:0] OP_UNKNOWN = 6'd36;

   // Decoded fields handed from the decoder to the result register
   typedef struct packed {
      logic [OP_W-1:0]    op_code;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg_a;
      logic [4:0]         src_reg_b;
      logic signed [31:0] immediate;
   } dec_result_type;

endpackage

`default_nettype wire

// ===== design/rvdec_if.sv =====
`default_nettype none

// Instruction beat into the decoder
interface rvdec_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;
   logic [31:0] fetch_pc;

   modport source (output valid, output instr_word, output fetch_pc, input ready);
   modport sink   (input valid, input instr_word, input fetch_pc, output ready);
endinterface

// Decoded beat out of the decoder
interface rvdec_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rvdec_pkg::OP_W-1:0]    op_code;
   logic [4:0]                    dest_reg;
   logic [4:0]                    src_reg_a;
   logic [4:0]                    src_reg_b;
   logic signed [31:0]            immediate;
   logic [31:0]                   pc_out;

   modport source (output valid, output op_code, output dest_reg, output src_reg_a,
                   output src_reg_b, output immediate, output pc_out, input ready);
   modport sink   (input valid, input op_code, input dest_reg, input src_reg_a,
                   input src_reg_b, input immediate, input pc_out, output ready);
endinterface

`default_nettype wire

// ===== design/rv32i_instruction_decoder_core.sv =====
`default_nettype none

// Channel   Dir  Handshake      Payload
// req_bus   in   valid/ready    instr_word[31:0], fetch_pc[31:0]
// rsp_bus   out  valid/ready    op_code[5:0], dest_reg, src_reg_a, src_reg_b[4:0],
//                               immediate[31:0] signed, pc_out[31:0]
//
// A req beat reaches rsp_bus through one input register, the decode logic
// and one result register. One beat per cycle is sustained unless rsp_bus stalls.
// Each register stage refills in the cycle it drains, so a stalled rsp_bus
// holds up req_bus only once both stages are full.
// reset (synchronous, active high) empties both stages.

module rv32i_instruction_decoder_core (
   input  wire logic      clock,
   input  wire logic      reset,
   rvdec_req_if.sink      req_bus,
   rvdec_rsp_if.source    rsp_bus
);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [31:0]               in_word_ff;
   logic [31:0]               in_pc_ff;
   logic                      in_ready;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic                      out_ready;
   rvdec_pkg::dec_result_type out_result_ff;
   logic [31:0]               out_pc_ff;
   rvdec_pkg::dec_result_type dec_result;

   // Each stage takes a beat when empty or draining
   assign out_ready = !out_valid_ff || rsp_bus.ready;
   assign in_ready  = !in_valid_ff || out_ready;

   assign in_valid_in  = req_bus.valid || (in_valid_ff && !out_ready);
   assign out_valid_in = in_valid_ff || (out_valid_ff && !rsp_bus.ready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_bus.valid) begin
         in_word_ff <= req_bus.instr_word;
         in_pc_ff   <= req_bus.fetch_pc;
      end
   end

   rvdec_decode u_decode (
      .instr_word (in_word_ff),
      .result     (dec_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && in_valid_ff) begin
         out_result_ff <= dec_result;
         out_pc_ff     <= in_pc_ff;
      end
   end

   assign req_bus.ready     = in_ready;
   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.op_code   = out_result_ff.op_code;
   assign rsp_bus.dest_reg  = out_result_ff.dest_reg;
   assign rsp_bus.src_reg_a = out_result_ff.src_reg_a;
   assign rsp_bus.src_reg_b = out_result_ff.src_reg_b;
   assign rsp_bus.immediate = out_result_ff.immediate;
   assign rsp_bus.pc_out    = out_pc_ff;

   // A halt beat carries no register or immediate
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_result_ff.op_code == rvdec_pkg::OP_HALT) |->
         (out_result_ff.dest_reg == '0) && (out_result_ff.src_reg_a == '0) &&
         (out_result_ff.src_reg_b == '0) && (out_result_ff.immediate == '0))
      else $error("halt beat with non-zero fields");

   // Stores and branches never name a destination
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_result_ff.op_code >= rvdec_pkg::OP_SB) &&
         (out_result_ff.op_code <= rvdec_pkg::OP_BNE) |->
         (out_result_ff.dest_reg == '0))
      else $error("store or branch with a destination register");

   // Shift-immediates carry only a five-bit amount
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && ((out_result_ff.op_code == rvdec_pkg::OP_SLLI) ||
         (out_result_ff.op_code == rvdec_pkg::OP_SRLI) ||
         (out_result_ff.op_code == rvdec_pkg::OP_SRAI)) |->
         (out_result_ff.immediate[31:5] == '0))
      else $error("shift amount wider than five bits");

   // A held input beat moves into the result register when it drains
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_ready |=> out_valid_ff)
      else $error("decoded beat lost between stages");

endmodule

`default_nettype wire

// ===== design/rvdec_decode.sv =====
`default_nettype none

module rvdec_decode (
   input  wire logic [31:0]              instr_word,
   output rvdec_pkg::dec_result_type     result
);

   logic [6:0]  opc;
   logic [2:0]  f3;
   logic        alt;
   logic [4:0]  rd;
   logic [4:0]  rs1;
   logic [4:0]  rs2;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic [31:0] imm_u;

   // Slice fields and build every immediate format
   assign opc   = instr_word[6:0];
   assign f3    = instr_word[14:12];
   assign alt   = (instr_word[31:25] == rvdec_pkg::FUNCT7_ALT);
   assign rd    = instr_word[11:7];
   assign rs1   = instr_word[19:15];
   assign rs2   = instr_word[24:20];
   assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
   assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
   assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                   instr_word[30:25], instr_word[11:8], 1'b0};
   assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                   instr_word[20], instr_word[30:21], 1'b0};
   assign imm_u = {instr_word[31:12], 12'b0};

   // Pick the operation, the immediate and the destination by opcode, funct3 and funct7
   always_comb begin
      logic halt;
      halt             = 1'b0;
      result.op_code   = rvdec_pkg::OP_HALT;
      result.dest_reg  = rd;
      result.src_reg_a = rs1;
      result.src_reg_b = rs2;
      result.immediate = '0;

      unique case (opc)
         rvdec_pkg::OPC_OP: begin
            unique case (f3)
               3'd0:    result.op_code = alt ? rvdec_pkg::OP_SUB : rvdec_pkg::OP_ADD;
               3'd1:    result.op_code = rvdec_pkg::OP_SLL;
               3'd2:    result.op_code = rvdec_pkg::OP_SLT;
               3'd3:    result.op_code = rvdec_pkg::OP_SLTU;
               3'd4:    result.op_code = rvdec_pkg::OP_XOR;
               3'd5:    result.op_code = alt ? rvdec_pkg::OP_SRA : rvdec_pkg::OP_SRL;
               3'd6:    result.op_code = rvdec_pkg::OP_OR;
               default: result.op_code = rvdec_pkg::OP_AND;
            endcase
         end
         rvdec_pkg::OPC_OP_IMM: begin
            result.immediate = imm_i;
            unique case (f3)
               3'd0:    result.op_code = rvdec_pkg::OP_ADDI;
               3'd1: begin
                  result.op_code   = rvdec_pkg::OP_SLLI;
                  result.immediate = {27'b0, rs2};
               end
               3'd4:    result.op_code = rvdec_pkg::OP_XORI;
               3'd5: begin
                  result.op_code   = alt ? rvdec_pkg::OP_SRAI : rvdec_pkg::OP_SRLI;
                  result.immediate = {27'b0, rs2};
               end
               3'd6:    result.op_code = rvdec_pkg::OP_ORI;
               3'd7:    result.op_code = rvdec_pkg::OP_ANDI;
               default: result.op_code = rvdec_pkg::OP_UNKNOWN;
            endcase
         end
         rvdec_pkg::OPC_LOAD: begin
            result.immediate = imm_i;
            unique case (f3)
               3'd0:    result.op_code = rvdec_pkg::OP_LB;
               3'd1:    result.op_code = rvdec_pkg::OP_LH;
               3'd2:    result.op_code = rvdec_pkg::OP_LW;
               3'd4:    result.op_code = rvdec_pkg::OP_LBU;
               3'd5:    result.op_code = rvdec_pkg::OP_LHU;
               default: result.op_code = rvdec_pkg::OP_UNKNOWN;
            endcase
         end
         rvdec_pkg::OPC_STORE: begin
            result.immediate = imm_s;
            result.dest_reg  = '0;
            unique case (f3)
               3'd0:    result.op_code = rvdec_pkg::OP_SB;
               3'd1:    result.op_code = rvdec_pkg::OP_SH;
               3'd2:    result.op_code = rvdec_pkg::OP_SW;
               default: begin
                  result.op_code  = rvdec_pkg::OP_UNKNOWN;
                  result.dest_reg = rd;
               end
            endcase
         end
         rvdec_pkg::OPC_BRANCH: begin
            result.immediate = imm_b;
            result.dest_reg  = '0;
            unique case (f3)
               3'd0:    result.op_code = rvdec_pkg::OP_BEQ;
               3'd1:    result.op_code = rvdec_pkg::OP_BNE;
               3'd4:    result.op_code = rvdec_pkg::OP_BLT;
               3'd5:    result.op_code = rvdec_pkg::OP_BGE;
               3'd6:    result.op_code = rvdec_pkg::OP_BLTU;
               3'd7:    result.op_code = rvdec_pkg::OP_BGEU;
               default: begin
                  result.op_code  = rvdec_pkg::OP_UNKNOWN;
                  result.dest_reg = rd;
               end
            endcase
         end
         rvdec_pkg::OPC_JAL: begin
            result.op_code   = rvdec_pkg::OP_JAL;
            result.immediate = imm_j;
         end
         rvdec_pkg::OPC_JALR: begin
            result.op_code   = rvdec_pkg::OP_JALR;
            result.immediate = imm_i;
         end
         rvdec_pkg::OPC_AUIPC: begin
            result.op_code   = rvdec_pkg::OP_AUIPC;
            result.immediate = imm_u;
         end
         rvdec_pkg::OPC_LUI: begin
            result.op_code   = rvdec_pkg::OP_LUI;
            result.immediate = imm_u;
         end
         default: halt = 1'b1;
      endcase

      // Halt word and unknown opcodes clear every field
      if (halt || (instr_word == rvdec_pkg::HALT_WORD)) begin
         result.op_code   = rvdec_pkg::OP_HALT;
         result.dest_reg  = '0;
         result.src_reg_a = '0;
         result.src_reg_b = '0;
         result.immediate = '0;
      end
   end

endmodule

`default_nettype wire
